[hw/rtl/svv_pkg.sv]
// shared types, constants and helper functions of the version string validator
`timescale 1ns / 1ps

package svv_pkg;

  // longest accepted string in bytes
  localparam int MAX_LENGTH = 64;
  // byte count runs up to MAX_LENGTH + 1 and sticks there
  localparam int BCNT_W     = $clog2(MAX_LENGTH + 2);

  // section codes
  localparam logic [1:0] SEC_CORE0 = 2'd0;
  localparam logic [1:0] SEC_CORE1 = 2'd1;
  localparam logic [1:0] SEC_CORE2 = 2'd2;
  localparam logic [1:0] SEC_PRE   = 2'd3;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;

  // one request as held in the input register
  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
  } item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  // field closes cleanly: non-empty, no leading zero when numeric
  function automatic logic field_ok(input logic [1:0] flen, input logic fzero,
                                    input logic fdig);
    return (flen != 2'd0) && !(fdig && (flen == 2'd2) && fzero);
  endfunction

endpackage

[hw/rtl/svv_in_reg.sv]
// input register stage holding one request
`timescale 1ns / 1ps

module svv_in_reg
  import svv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  fire_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || fire_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (fire_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/svv_parse.sv]
// parse state registers, per-byte update and end-of-string verdict
`timescale 1ns / 1ps

module svv_parse
  import svv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  output logic  verdict_o
);

  logic [1:0]        section_q, section_d;
  logic [1:0]        flen_q, flen_d;
  logic              fzero_q, fzero_d;
  logic              fdig_q, fdig_d;
  logic              failed_q, failed_d;
  logic [BCNT_W-1:0] bcnt_q, bcnt_d;

  // state after applying the byte of this request (if any)
  logic [1:0]        sec_n;
  logic [1:0]        flen_n;
  logic              fzero_n, fdig_n, failed_n;
  logic [BCNT_W-1:0] bcnt_n;

  always_comb begin
    logic [7:0] c;
    logic       take;
    logic       newf;
    c        = item_i.character;
    take     = 1'b0;
    newf     = 1'b0;
    sec_n    = section_q;
    flen_n   = flen_q;
    fzero_n  = fzero_q;
    fdig_n   = fdig_q;
    failed_n = failed_q;
    bcnt_n   = bcnt_q;
    if (item_i.has_char) begin
      if (bcnt_q < BCNT_W'(MAX_LENGTH + 1)) begin
        bcnt_n = bcnt_q + BCNT_W'(1);
      end
      if (c == CH_PLUS) begin
        failed_n = 1'b1;
      end
      if (section_q != SEC_PRE) begin
        if (c == CH_DOT) begin
          newf = 1'b1;
          if ((section_q == SEC_CORE2) || !field_ok(flen_q, fzero_q, fdig_q)) begin
            failed_n = 1'b1;
          end else begin
            sec_n = section_q + 2'd1;
          end
        end else if (c == CH_DASH) begin
          newf  = 1'b1;
          sec_n = SEC_PRE;
          if ((section_q != SEC_CORE2) || !field_ok(flen_q, fzero_q, fdig_q)) begin
            failed_n = 1'b1;
          end
        end else if (is_digit(c)) begin
          take = 1'b1;
        end else begin
          failed_n = 1'b1;
        end
      end else begin
        if (c == CH_DOT) begin
          newf = 1'b1;
          if (!field_ok(flen_q, fzero_q, fdig_q)) begin
            failed_n = 1'b1;
          end
        end else if (is_alnum(c) || (c == CH_DASH)) begin
          take = 1'b1;
        end else begin
          failed_n = 1'b1;
        end
      end
      if (newf) begin
        flen_n  = 2'd0;
        fzero_n = 1'b0;
        fdig_n  = 1'b1;
      end
      if (take) begin
        if (flen_q == 2'd0) begin
          fzero_n = (c == CH_ZERO);
        end
        if (!is_digit(c)) begin
          fdig_n = 1'b0;
        end
        if (flen_q != 2'd2) begin
          flen_n = flen_q + 2'd1;
        end
      end
    end
  end

  assign verdict_o = !failed_n && (bcnt_n != '0) &&
                     (bcnt_n <= BCNT_W'(MAX_LENGTH)) &&
                     (sec_n != SEC_CORE0) && (sec_n != SEC_CORE1) &&
                     field_ok(flen_n, fzero_n, fdig_n);

  // end of string returns everything to reset
  always_comb begin
    section_d = section_q;
    flen_d    = flen_q;
    fzero_d   = fzero_q;
    fdig_d    = fdig_q;
    failed_d  = failed_q;
    bcnt_d    = bcnt_q;
    if (fire_i) begin
      if (item_i.last) begin
        section_d = SEC_CORE0;
        flen_d    = 2'd0;
        fzero_d   = 1'b0;
        fdig_d    = 1'b1;
        failed_d  = 1'b0;
        bcnt_d    = '0;
      end else begin
        section_d = sec_n;
        flen_d    = flen_n;
        fzero_d   = fzero_n;
        fdig_d    = fdig_n;
        failed_d  = failed_n;
        bcnt_d    = bcnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_q <= SEC_CORE0;
      flen_q    <= 2'd0;
      fzero_q   <= 1'b0;
      fdig_q    <= 1'b1;
      failed_q  <= 1'b0;
      bcnt_q    <= '0;
    end else begin
      section_q <= section_d;
      flen_q    <= flen_d;
      fzero_q   <= fzero_d;
      fdig_q    <= fdig_d;
      failed_q  <= failed_d;
      bcnt_q    <= bcnt_d;
    end
  end

endmodule

[hw/rtl/svv_out_reg.sv]
// result register holding one verdict until taken
`timescale 1ns / 1ps

module svv_out_reg
  import svv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic verdict_i,
  output logic can_load_o,
  output logic valid_o,
  input  logic ready_i,
  output logic verdict_o
);

  logic valid_q, valid_d;
  logic verdict_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i ? 1'b1 : ((valid_q && ready_i) ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;

endmodule

[hw/rtl/semver_string_validator_top.sv]
// top level of the semantic version string validator
`timescale 1ns / 1ps

// Checks a version string streamed in one byte per request and gives one
// verdict request per string, on the request marked tlast. A string passes
// when it is three dot-separated decimal core numbers without leading zeros,
// optionally followed by a dash and a non-empty dot-separated prerelease of
// letters, digits and dash (numeric identifiers without leading zero); any
// '+', an empty string or more than MAX_LENGTH bytes fails. Throughput is one
// request per cycle while the result register has room for a string end; each
// byte goes from the input register through the parse update into the state
// and result registers. A request with tuser low carries no byte; with tlast
// high it only closes the string.

module semver_string_validator_top
  import svv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] character
  input  logic       s_axis_tuser,   // [0] has_char
  input  logic       s_axis_tlast,
  // verdict stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] valid_res, [7:1] zero
);

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_fire;
  logic  out_can_load;
  logic  verdict;
  logic  out_verdict;

  assign in_item.character = s_axis_tdata;
  assign in_item.has_char  = s_axis_tuser;
  assign in_item.last      = s_axis_tlast;

  // a string end needs room in the result register, other bytes never stall
  assign s1_fire = s1_valid && (!s1_item.last || out_can_load);

  svv_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .fire_i  (s1_fire),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  svv_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_fire),
    .item_i    (s1_item),
    .verdict_o (verdict)
  );

  svv_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s1_fire && s1_item.last),
    .verdict_i  (verdict),
    .can_load_o (out_can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .verdict_o  (out_verdict)
  );

  assign m_axis_tdata = {7'd0, out_verdict};

endmodule
